>>> rtl/core/stc_pkg.sv
// Shared types, constants and codes for the signature table catalog.
package stc_pkg;

	localparam int SigW      = 64;
	localparam int IdxW      = 6;
	localparam int CountW    = 7;
	localparam int MaxSlots  = 64;
	localparam int DefComponents = 64;
	localparam int DefTables     = 64;

	localparam logic [1:0] ModeLookup = 2'd0;
	localparam logic [1:0] ModeEnsure = 2'd1;
	localparam logic [1:0] ModeQuery  = 2'd2;

	typedef struct packed {
		logic [1:0]      mode;
		logic [SigW-1:0] signature;
	} req_t;

	typedef struct packed {
		logic [IdxW-1:0]   slot_index;
		logic              found;
		logic              inserted;
		logic              full_res;
		logic [SigW-1:0]   match_mask;
		logic [IdxW-1:0]   seed_component;
		logic              seed_found;
		logic [CountW-1:0] table_count;
	} rsp_t;

	// Compare results for one stored signature against the item's set.
	typedef struct packed {
		logic eq;
		logic covers;
		logic seed_hit;
	} cmp_t;

endpackage

>>> rtl/core/stc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stc_ram #(
	parameter int W     = 64,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/stc_match_unit.sv
// Shared compare unit: checks one stored signature against the item's set.
module stc_match_unit (
	input  logic [stc_pkg::SigW-1:0] entry,
	input  logic [stc_pkg::SigW-1:0] sig,
	input  logic [stc_pkg::SigW-1:0] seed_onehot,
	output stc_pkg::cmp_t            cmp
);

	always_comb begin
		cmp.eq       = (entry == sig);
		// The entry holds every required component.
		cmp.covers   = ((entry & sig) == sig);
		// The entry holds the seed candidate, so its column is nonzero.
		cmp.seed_hit = |(entry & seed_onehot);
	end

endmodule

>>> rtl/core/signature_table_catalog_core.sv
// Top level of the signature table catalog: sequencer, scan and result register.
// An item passes through the scan and finish states before its result is registered; the
// finish state holds while the result register is still stalled.
// Throughput: one item at a time; the scan reads one stored signature per cycle from the
// single read port of the signature RAM, and a new item is taken once the sequencer is idle.
// Reset clears the slot count, the sequencer and the result valid; the signature RAM is not
// cleared, since only slots below the count are ever read. No clearing pass is needed.
module signature_table_catalog_core #(
	parameter int COMPONENTS = stc_pkg::DefComponents,
	parameter int TABLES     = stc_pkg::DefTables
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stc_pkg::rsp_t rsp
);

	// Address width of the signature RAM, which holds one entry per table slot.
	localparam int TblAw = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam logic [stc_pkg::CountW-1:0] SlotLimit = stc_pkg::CountW'(TABLES);
	// Signature bits at or above COMPONENTS are ignored in every mode.
	localparam logic [stc_pkg::SigW:0] CompMaskWide =
		(65'd1 << COMPONENTS) - 65'd1;
	localparam logic [stc_pkg::SigW-1:0] CompMask = CompMaskWide[stc_pkg::SigW-1:0];

	typedef enum logic [2:0] {
		StIdle = 3'b001,
		StScan = 3'b010,
		StFin  = 3'b100
	} state_t;

	state_t                         state_q;
	logic [1:0]                     mode_q;
	logic [stc_pkg::SigW-1:0]       sig_q;
	logic [stc_pkg::SigW-1:0]       low_q;
	logic [stc_pkg::CountW-1:0]     idx_q;
	logic                           pend_q;
	logic [stc_pkg::IdxW-1:0]       pidx_q;
	logic                           hit_q;
	logic [stc_pkg::IdxW-1:0]       hit_idx_q;
	logic [stc_pkg::SigW-1:0]       match_q;
	logic                           seed_any_q;
	logic [stc_pkg::CountW-1:0]     used_q;
	logic                           rsp_valid_q;
	stc_pkg::rsp_t                  rsp_q;

	logic                           req_acc;
	logic [stc_pkg::SigW-1:0]       sig_in;
	logic                           issue;
	logic                           rsp_free;
	logic                           load;
	logic                           do_ins;
	logic [stc_pkg::SigW-1:0]       ram_rdata;
	stc_pkg::cmp_t                  cmp;
	stc_pkg::rsp_t                  rsp_d;

	// Index of the single set bit of the seed candidate.
	function automatic logic [stc_pkg::IdxW-1:0] enc_onehot(
		input logic [stc_pkg::SigW-1:0] oh
	);
		logic [stc_pkg::IdxW-1:0] r;
		r = '0;
		for (int i = 0; i < stc_pkg::SigW; i++) begin
			if (oh[i]) begin
				r = r | stc_pkg::IdxW'(i);
			end
		end
		return r;
	endfunction

	assign req_stall = (state_q != StIdle);
	assign req_acc   = req_valid && !req_stall;
	assign sig_in    = req.signature & CompMask;

	// The scan issues one RAM read per cycle while slots remain; the registered data comes back
	// in the next cycle and goes through the shared compare unit.
	assign issue    = (state_q == StScan) && (idx_q < used_q);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign load     = (state_q == StFin) && rsp_free;

	// A new signature goes into the next free slot, unless the catalog is full.
	assign do_ins = (mode_q == stc_pkg::ModeEnsure) && !hit_q && (used_q < SlotLimit);

	stc_ram #(
		.W     (stc_pkg::SigW),
		.DEPTH (TABLES),
		.AW    (TblAw)
	) u_sig_ram (
		.clk   (clk),
		.we    (load && do_ins),
		.waddr (used_q[TblAw-1:0]),
		.wdata (sig_q),
		.re    (issue),
		.raddr (idx_q[TblAw-1:0]),
		.rdata (ram_rdata)
	);

	stc_match_unit u_match (
		.entry       (ram_rdata),
		.sig         (sig_q),
		.seed_onehot (low_q),
		.cmp         (cmp)
	);

	// Result of the item, assembled once the scan is over.
	always_comb begin
		logic is_lu;
		logic is_q;
		is_lu = (mode_q == stc_pkg::ModeLookup) || (mode_q == stc_pkg::ModeEnsure);
		is_q  = (mode_q == stc_pkg::ModeQuery);
		rsp_d.found      = is_lu && hit_q;
		rsp_d.inserted   = do_ins;
		rsp_d.full_res   = (mode_q == stc_pkg::ModeEnsure) && !hit_q && (used_q >= SlotLimit);
		if (is_lu && hit_q) begin
			rsp_d.slot_index = hit_idx_q;
		end else if (do_ins) begin
			rsp_d.slot_index = used_q[stc_pkg::IdxW-1:0];
		end else begin
			rsp_d.slot_index = '0;
		end
		// An empty required set matches no table.
		rsp_d.match_mask     = (is_q && (sig_q != '0)) ? match_q : '0;
		rsp_d.seed_found     = is_q && seed_any_q;
		rsp_d.seed_component = (is_q && seed_any_q) ? enc_onehot(low_q) : '0;
		rsp_d.table_count    = do_ins ? (used_q + stc_pkg::CountW'(1)) : used_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			used_q      <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (req_acc) begin
						state_q <= StScan;
					end
					pend_q <= 1'b0;
				end
				StScan: begin
					pend_q <= issue;
					if (!issue && !pend_q) begin
						state_q <= StFin;
					end
				end
				StFin: begin
					if (load) begin
						state_q <= StIdle;
						if (do_ins) begin
							used_q <= used_q + stc_pkg::CountW'(1);
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// Item and scan payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q     <= req.mode;
			sig_q      <= sig_in;
			// Lowest set bit of the required set is the seed candidate.
			low_q      <= sig_in & (~sig_in + stc_pkg::SigW'(1));
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			match_q    <= '0;
			seed_any_q <= 1'b0;
		end else if (state_q == StScan) begin
			if (issue) begin
				idx_q  <= idx_q + stc_pkg::CountW'(1);
				pidx_q <= idx_q[stc_pkg::IdxW-1:0];
			end
			if (pend_q) begin
				if (cmp.eq && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= pidx_q;
				end
				if (cmp.covers) begin
					match_q[pidx_q] <= 1'b1;
				end
				if (cmp.seed_hit) begin
					seed_any_q <= 1'b1;
				end
			end
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The slot count never passes the number of tables.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SlotLimit)
		else $error("slot count beyond table limit");

	// At most one of found, inserted and full is reported for an item.
	a_outcome_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> $onehot0({rsp_q.found, rsp_q.inserted, rsp_q.full_res}))
		else $error("conflicting lookup outcome");

	// An inserted signature lands in the last slot of the updated count.
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.inserted) |->
			(rsp_q.table_count == ({1'b0, rsp_q.slot_index} + stc_pkg::CountW'(1))))
		else $error("inserted slot does not match table count");

	// The scan only reads slots that have been written.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (idx_q < used_q))
		else $error("scan read past stored signatures");

endmodule
